/* rtl/flash_block_store_with_wear_top_defines.svh */
// Assertion macros used by the top-level RTL file.
`ifndef FLASH_BLOCK_STORE_WITH_WEAR_TOP_DEFINES_SVH
`define FLASH_BLOCK_STORE_WITH_WEAR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define FSBW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FSBW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSBW_ASSERT(lbl, clk, rstn, prop, msg)
`define FSBW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/fsbw_pkg.sv */
package fsbw_pkg;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_ERASE  = 3'd2,
        OP_MARK   = 3'd3,
        OP_QUERY  = 3'd4,
        OP_TOTALS = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_IO    = 2'd1,
        ST_INVAL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_READY = 3'b010,
        S_ERASE = 3'b100
    } state_t;

    localparam int WEAR_W  = 17;
    localparam int SUM_W   = 25;
    localparam int BSUM_W  = 9;
    localparam int LIMIT_W = 16;
    localparam int BIU_W   = 9;

    typedef struct packed {
        logic              bad;
        logic [WEAR_W-1:0] wear;
    } info_t;

    localparam logic [WEAR_W-1:0]  WEAR_MAX     = 17'h1FFFF;
    localparam logic [SUM_W-1:0]   SUM_MAX      = 25'h1FFFFFF;
    localparam logic [7:0]         ERASED_BYTE  = 8'hFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd10000;
    localparam logic [BIU_W-1:0]   BLOCKS_RESET = 9'd256;

    localparam logic CFG_ERASE_LIMIT   = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

endpackage

/* rtl/fsbw_ram.sv */
module fsbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/flash_block_store_with_wear_top.sv */
// Channel   Direction  Transaction
// s_axis    in         one operation: opcode, block, offset, write byte
// m_axis    out        one result per operation: status, byte, flag, totals
// cfg       in         register write, taken on any cycle with cfg_we high
//
// Reads, writes, mark bad, queries and totals are accepted back to back while m_tready does not stall.
// Any erase holds s_tready low while it waits in the pipeline register; a successful one
// then holds it low while the sweep rewrites every byte of the block with 0xFF.
// After reset a clearing pass writes 0xFF to all BLOCK_COUNT * BLOCK_BYTES bytes, one
// per cycle, and clears the block info memory; s_tready stays low until it ends.
// A stalled m_tready holds the result register and the item behind it.
`include "flash_block_store_with_wear_top_defines.svh"

module flash_block_store_with_wear_top #(
    parameter int BLOCK_COUNT = 256,
    parameter int BLOCK_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] opcode, [10:3] block_index, [19:11] byte_offset, [27:20] write_byte
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [9:2] read_byte, [10] block_is_bad, [35:11] total_erases,
    // [44:36] bad_block_total
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int DEPTH    = BLOCK_COUNT * BLOCK_BYTES;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int BLK_W    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int INFO_W   = $bits(fsbw_pkg::info_t);
    localparam int CMP_W    = 14;
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] BYTES_A    = ADDR_W'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] BYTES_M1_A = ADDR_W'(BLOCK_BYTES - 1);
    localparam logic [ADDR_W-1:0] COUNT_A    = ADDR_W'(BLOCK_COUNT);

    logic [fsbw_pkg::LIMIT_W-1:0] erase_limit_reg;
    logic [fsbw_pkg::BIU_W-1:0]   blocks_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_limit_reg   <= fsbw_pkg::LIMIT_RESET;
            blocks_in_use_reg <= fsbw_pkg::BLOCKS_RESET;
        end else if (cfg_we) begin
            if (cfg_index == fsbw_pkg::CFG_ERASE_LIMIT) begin
                erase_limit_reg <= cfg_wdata;
            end else begin
                blocks_in_use_reg <= cfg_wdata[fsbw_pkg::BIU_W-1:0];
            end
        end
    end

    logic [2:0]  s_op;
    logic [7:0]  s_blk;
    logic [8:0]  s_off;
    logic [7:0]  s_wbyte;
    logic [BLK_W-1:0]  s_blk_idx;
    logic [ADDR_W-1:0] s_addr;
    logic        s_accept;

    assign s_op      = s_tdata[2:0];
    assign s_blk     = s_tdata[10:3];
    assign s_off     = s_tdata[19:11];
    assign s_wbyte   = s_tdata[27:20];
    assign s_blk_idx = BLK_W'(s_blk);
    assign s_addr    = ADDR_W'(s_blk_idx) * BYTES_A + ADDR_W'(s_off);

    fsbw_pkg::state_t  state_reg, state_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_end_reg, sweep_end_next;

    logic              p1_valid_reg, p1_valid_next;
    logic [2:0]        p1_op_reg;
    logic [7:0]        p1_blk_reg;
    logic [8:0]        p1_off_reg;
    logic [7:0]        p1_wbyte_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic              data_fwd_reg, data_fwd_next;
    logic [7:0]        data_fwd_byte_reg;
    logic              info_fwd_reg, info_fwd_next;
    fsbw_pkg::info_t   info_fwd_data_reg;

    logic                        m_valid_reg, m_valid_next;
    logic [47:0]                 m_data_reg;
    logic [fsbw_pkg::SUM_W-1:0]  erase_sum_reg, erase_sum_next;
    logic [fsbw_pkg::BSUM_W-1:0] bad_sum_reg, bad_sum_next;

    logic              p1_fire;
    logic              erase_pending;
    logic [BLK_W-1:0]  p1_blk_idx;
    logic [CMP_W-1:0]  blk_lim;
    logic              blk_ok;
    logic              off_ok;
    logic [7:0]        data_rdata;
    logic [INFO_W-1:0] info_rdata;
    fsbw_pkg::info_t   info_cur;
    fsbw_pkg::info_t   info_new;
    logic [7:0]        byte_cur;
    logic [fsbw_pkg::WEAR_W-1:0] wear_new;
    fsbw_pkg::status_t res_status;
    logic [7:0]        res_byte;
    logic              res_isbad;
    logic [fsbw_pkg::SUM_W-1:0]  res_te;
    logic [fsbw_pkg::BSUM_W-1:0] res_tb;
    logic              data_we_raw;
    logic              info_we_raw;
    logic              item_dwe;
    logic              item_iwe;
    logic              erase_go;
    logic              erase_inc;
    logic              bad_inc;
    logic [ADDR_W-1:0] p1_base;

    logic              sweep_we;
    logic              clear_we;
    logic              dram_we;
    logic [ADDR_W-1:0] dram_waddr;
    logic [7:0]        dram_wdata;
    logic              iram_we;
    logic [BLK_W-1:0]  iram_waddr;
    logic [INFO_W-1:0] iram_wdata;

    assign p1_blk_idx    = BLK_W'(p1_blk_reg);
    assign p1_fire       = p1_valid_reg && (!m_valid_reg || m_tready);
    assign erase_pending = p1_valid_reg && (p1_op_reg == fsbw_pkg::OP_ERASE);
    assign s_tready      = (state_reg == fsbw_pkg::S_READY)
                           && !erase_pending
                           && (!p1_valid_reg || p1_fire);
    assign s_accept      = s_tvalid && s_tready;

    always_comb begin
        if (CMP_W'(blocks_in_use_reg) > CMP_W'(BLOCK_COUNT)) begin
            blk_lim = CMP_W'(BLOCK_COUNT);
        end else begin
            blk_lim = CMP_W'(blocks_in_use_reg);
        end
    end

    assign blk_ok   = CMP_W'(p1_blk_reg) < blk_lim;
    assign off_ok   = CMP_W'(p1_off_reg) < CMP_W'(BLOCK_BYTES);
    assign info_cur = info_fwd_reg ? info_fwd_data_reg : fsbw_pkg::info_t'(info_rdata);
    assign byte_cur = data_fwd_reg ? data_fwd_byte_reg : data_rdata;
    assign wear_new = (info_cur.wear < fsbw_pkg::WEAR_MAX) ? info_cur.wear + 1'b1
                                                           : info_cur.wear;
    assign p1_base  = ADDR_W'(p1_blk_idx) * BYTES_A;

    always_comb begin
        res_status  = fsbw_pkg::ST_OK;
        res_byte    = '0;
        res_isbad   = 1'b0;
        res_te      = '0;
        res_tb      = '0;
        data_we_raw = 1'b0;
        info_we_raw = 1'b0;
        erase_go    = 1'b0;
        erase_inc   = 1'b0;
        bad_inc     = 1'b0;
        info_new    = info_cur;
        case (fsbw_pkg::op_t'(p1_op_reg))
            fsbw_pkg::OP_READ, fsbw_pkg::OP_WRITE: begin
                if (!blk_ok || !off_ok) begin
                    res_status = fsbw_pkg::ST_INVAL;
                end else if (info_cur.bad) begin
                    res_status = fsbw_pkg::ST_IO;
                end else if (p1_op_reg == fsbw_pkg::OP_READ) begin
                    res_byte = byte_cur;
                end else begin
                    data_we_raw = 1'b1;
                end
            end
            fsbw_pkg::OP_ERASE: begin
                if (!blk_ok) begin
                    res_status = fsbw_pkg::ST_INVAL;
                end else if (info_cur.bad) begin
                    res_status = fsbw_pkg::ST_IO;
                end else begin
                    info_we_raw   = 1'b1;
                    erase_inc     = 1'b1;
                    info_new.wear = wear_new;
                    if (wear_new > fsbw_pkg::WEAR_W'(erase_limit_reg)) begin
                        info_new.bad = 1'b1;
                        bad_inc      = 1'b1;
                        res_status   = fsbw_pkg::ST_IO;
                    end else begin
                        erase_go = 1'b1;
                    end
                end
            end
            fsbw_pkg::OP_MARK: begin
                if (!blk_ok) begin
                    res_status = fsbw_pkg::ST_INVAL;
                end else if (!info_cur.bad) begin
                    info_we_raw  = 1'b1;
                    info_new.bad = 1'b1;
                    bad_inc      = 1'b1;
                end
            end
            fsbw_pkg::OP_QUERY: begin
                res_isbad = !blk_ok || info_cur.bad;
            end
            fsbw_pkg::OP_TOTALS: begin
                res_te = erase_sum_reg;
                res_tb = bad_sum_reg;
            end
            default: begin
                res_status = fsbw_pkg::ST_INVAL;
            end
        endcase
    end

    always_comb begin
        erase_sum_next = erase_sum_reg;
        bad_sum_next   = bad_sum_reg;
        if (p1_fire && erase_inc && (erase_sum_reg != fsbw_pkg::SUM_MAX)) begin
            erase_sum_next = erase_sum_reg + 1'b1;
        end
        if (p1_fire && bad_inc) begin
            bad_sum_next = bad_sum_reg + 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        case (state_reg)
            fsbw_pkg::S_CLEAR, fsbw_pkg::S_ERASE: begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == sweep_end_reg) begin
                    state_next = fsbw_pkg::S_READY;
                end
            end
            fsbw_pkg::S_READY: begin
                if (p1_fire && erase_go) begin
                    state_next      = fsbw_pkg::S_ERASE;
                    sweep_addr_next = p1_base;
                    sweep_end_next  = p1_base + BYTES_M1_A;
                end
            end
            default: begin
                state_next = fsbw_pkg::S_READY;
            end
        endcase
    end

    assign item_dwe   = p1_fire && data_we_raw;
    assign item_iwe   = p1_fire && info_we_raw;
    assign sweep_we   = (state_reg != fsbw_pkg::S_READY);
    assign clear_we   = (state_reg == fsbw_pkg::S_CLEAR) && (sweep_addr_reg < COUNT_A);
    assign dram_we    = sweep_we || item_dwe;
    assign dram_waddr = sweep_we ? sweep_addr_reg : p1_addr_reg;
    assign dram_wdata = sweep_we ? fsbw_pkg::ERASED_BYTE : p1_wbyte_reg;
    assign iram_we    = clear_we || item_iwe;
    assign iram_waddr = clear_we ? BLK_W'(sweep_addr_reg) : p1_blk_idx;
    assign iram_wdata = clear_we ? '0 : INFO_W'(info_new);

    assign data_fwd_next = item_dwe && (p1_addr_reg == s_addr);
    assign info_fwd_next = item_iwe && (p1_blk_idx == s_blk_idx);

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_fire) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    fsbw_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .aclk    (aclk),
        .we      (dram_we),
        .wr_addr (dram_waddr),
        .wr_data (dram_wdata),
        .rd_en   (s_accept),
        .rd_addr (s_addr),
        .rd_data (data_rdata)
    );

    fsbw_ram #(
        .WIDTH (INFO_W),
        .DEPTH (BLOCK_COUNT)
    ) u_info_ram (
        .aclk    (aclk),
        .we      (iram_we),
        .wr_addr (iram_waddr),
        .wr_data (iram_wdata),
        .rd_en   (s_accept),
        .rd_addr (s_blk_idx),
        .rd_data (info_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fsbw_pkg::S_CLEAR;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= LAST_ADDR;
            p1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            erase_sum_reg  <= '0;
            bad_sum_reg    <= '0;
            data_fwd_reg   <= 1'b0;
            info_fwd_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            p1_valid_reg   <= p1_valid_next;
            m_valid_reg    <= m_valid_next;
            erase_sum_reg  <= erase_sum_next;
            bad_sum_reg    <= bad_sum_next;
            if (s_accept) begin
                data_fwd_reg <= data_fwd_next;
                info_fwd_reg <= info_fwd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_op_reg         <= s_op;
            p1_blk_reg        <= s_blk;
            p1_off_reg        <= s_off;
            p1_wbyte_reg      <= s_wbyte;
            p1_addr_reg       <= s_addr;
            data_fwd_byte_reg <= p1_wbyte_reg;
            info_fwd_data_reg <= info_new;
        end
        if (p1_fire) begin
            m_data_reg <= {3'b000, res_tb, res_te, res_isbad, res_byte, res_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `FSBW_ASSERT(a_erase_interlock, aclk, aresetn, erase_pending |-> !s_tready, "accept behind erase")
    `FSBW_ASSERT(a_single_data_writer, aclk, aresetn, !(sweep_we && item_dwe), "data write collision")
    `FSBW_ASSERT(a_info_single_writer, aclk, aresetn, !(clear_we && item_iwe), "info write collision")
    `FSBW_ASSERT_ALWAYS(a_reset_blocks_input, aclk, !aresetn |=> !s_tready, "ready during clear")

endmodule

/* dv/tb_flash_block_store_with_wear_top.sv */
module tb_flash_block_store_with_wear_top;
    import fsbw_pkg::*;

    localparam int BLOCK_COUNT = 256;
    localparam int BLOCK_BYTES = 512;
    localparam int HALF_PERIOD = 5;
    localparam int IDLE_MAX = 19;
    localparam int SETTLE_CYCLES = BLOCK_BYTES + 16;
    localparam int PHASES = 8;
    localparam logic [2:0] OPC_SPARE_6 = 3'd6;
    localparam logic [2:0] OPC_SPARE_7 = 3'd7;

    typedef struct packed {
        status_t           status;
        logic [7:0]        rd_byte;
        logic              is_bad;
        logic [SUM_W-1:0]  erases;
        logic [BSUM_W-1:0] bad_count;
    } flash_result_t;

    typedef enum logic {
        ROW_CFG,
        ROW_OP
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic          reg_sel;
        logic [15:0]   reg_val;
        logic [2:0]    opc;
        logic [7:0]    blk;
        logic [8:0]    off;
        logic [7:0]    wbyte;
        logic          typed;
        flash_result_t typed_result;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [2:0] opcode, [10:3] block_index, [19:11] byte_offset, [27:20] write_byte
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [1:0] status, [9:2] read_byte, [10] block_is_bad, [35:11] total_erases,
    // [44:36] bad_block_total
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    logic [7:0]         flash_mem [BLOCK_COUNT*BLOCK_BYTES];
    logic [WEAR_W-1:0]  wear_cnt [BLOCK_COUNT];
    logic               bad_flag [BLOCK_COUNT];
    logic [SUM_W-1:0]   erase_total;
    logic [BSUM_W-1:0]  bad_total;
    logic [LIMIT_W-1:0] limit_reg;
    logic [BIU_W-1:0]   biu_reg;

    flash_result_t expected_q [$];
    stim_row_t     directed_rows [$];
    int            errors;
    bit            no_idle;

    int phase_limit [PHASES] = '{65535, 3, 1, 0, 2, 1, 5, 10000};
    int phase_biu [PHASES] = '{256, 16, 511, 40, 200, 1, 0, 256};
    int phase_items [PHASES] = '{130, 120, 120, 110, 130, 100, 30, 130};

    always #HALF_PERIOD aclk = ~aclk;

    flash_block_store_with_wear_top #(
        .BLOCK_COUNT(BLOCK_COUNT),
        .BLOCK_BYTES(BLOCK_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    function automatic int usable_blocks();
        return (biu_reg > BLOCK_COUNT) ? BLOCK_COUNT : int'(biu_reg);
    endfunction

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic flash_result_t apply_op(input logic [2:0] opc, input logic [7:0] blk,
                                               input logic [8:0] off, input logic [7:0] wbyte);
        flash_result_t res;
        logic          blk_ok;
        int            base;
        res = '0;
        res.status = ST_OK;
        blk_ok = int'(blk) < usable_blocks();
        base = int'(blk) * BLOCK_BYTES;
        case (opc)
            OP_READ, OP_WRITE: begin
                if (!blk_ok || int'(off) >= BLOCK_BYTES) begin
                    res.status = ST_INVAL;
                end else if (bad_flag[blk]) begin
                    res.status = ST_IO;
                end else if (opc == OP_READ) begin
                    res.rd_byte = flash_mem[base + int'(off)];
                end else begin
                    flash_mem[base + int'(off)] = wbyte;
                end
            end
            OP_ERASE: begin
                if (!blk_ok) begin
                    res.status = ST_INVAL;
                end else if (bad_flag[blk]) begin
                    res.status = ST_IO;
                end else begin
                    if (wear_cnt[blk] != WEAR_MAX) wear_cnt[blk]++;
                    if (erase_total != SUM_MAX) erase_total++;
                    if (wear_cnt[blk] > limit_reg) begin
                        bad_flag[blk] = 1'b1;
                        bad_total++;
                        res.status = ST_IO;
                    end else begin
                        for (int i = 0; i < BLOCK_BYTES; i++) flash_mem[base + i] = ERASED_BYTE;
                    end
                end
            end
            OP_MARK: begin
                if (!blk_ok) begin
                    res.status = ST_INVAL;
                end else if (!bad_flag[blk]) begin
                    bad_flag[blk] = 1'b1;
                    bad_total++;
                end
            end
            OP_QUERY: begin
                res.is_bad = !blk_ok || bad_flag[blk];
            end
            OP_TOTALS: begin
                res.erases = erase_total;
                res.bad_count = bad_total;
            end
            default: begin
                res.status = ST_INVAL;
            end
        endcase
        return res;
    endfunction

    task automatic add_cfg(input logic sel, input logic [15:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_sel = sel;
        row.reg_val = val;
        directed_rows.push_back(row);
    endtask

    task automatic add_op(input logic [2:0] opc, input logic [7:0] blk, input logic [8:0] off,
                          input logic [7:0] wbyte);
        stim_row_t row;
        row = '0;
        row.kind = ROW_OP;
        row.opc = opc;
        row.blk = blk;
        row.off = off;
        row.wbyte = wbyte;
        directed_rows.push_back(row);
    endtask

    task automatic add_chk(input logic [2:0] opc, input logic [7:0] blk, input logic [8:0] off,
                           input logic [7:0] wbyte, input status_t st, input logic [7:0] rd,
                           input logic isbad);
        add_op(opc, blk, off, wbyte);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].typed_result.status = st;
        directed_rows[$].typed_result.rd_byte = rd;
        directed_rows[$].typed_result.is_bad = isbad;
    endtask

    task automatic send_op(input logic [2:0] opc, input logic [7:0] blk, input logic [8:0] off,
                           input logic [7:0] wbyte, input logic typed,
                           input flash_result_t typed_result);
        flash_result_t predicted;
        int            gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, wbyte, off, blk, opc};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = apply_op(opc, blk, off, wbyte);
        expected_q.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (sel == CFG_ERASE_LIMIT) begin
            limit_reg = val;
        end else begin
            biu_reg = val[BIU_W-1:0];
        end
    endtask

    task automatic send_random(input int hot_base);
        int         pick;
        int         span;
        int         r;
        logic [2:0] opc;
        logic [7:0] blk;
        logic [8:0] off;
        span = usable_blocks();
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            opc = OP_READ;
        end else if (pick < 60) begin
            opc = OP_WRITE;
        end else if (pick < 70) begin
            opc = OP_ERASE;
        end else if (pick < 72) begin
            opc = OP_MARK;
        end else if (pick < 83) begin
            opc = OP_QUERY;
        end else if (pick < 93) begin
            opc = OP_TOTALS;
        end else begin
            opc = pick[0] ? OPC_SPARE_7 : OPC_SPARE_6;
        end
        r = $urandom_range(0, 99);
        if (span == 0 || r >= 85) begin
            blk = 8'($urandom_range(0, 255));
        end else if (r < 40) begin
            blk = 8'(hot_base + $urandom_range(0, ((span < 8) ? span : 8) - 1));
        end else begin
            blk = 8'($urandom_range(0, span - 1));
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
            off = 9'($urandom_range(0, 15));
        end else if (r == 5) begin
            off = '0;
        end else if (r == 6) begin
            off = 9'(BLOCK_BYTES - 1);
        end else begin
            off = 9'($urandom_range(0, 511));
        end
        send_op(opc, blk, off, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    initial begin
        flash_result_t want;
        int            stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %0h", $time, m_tdata);
            end else begin
                want = expected_q.pop_front();
                check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                check_field("read_byte", 32'(want.rd_byte), 32'(m_tdata[9:2]));
                check_field("block_is_bad", 32'(want.is_bad), 32'(m_tdata[10]));
                check_field("total_erases", 32'(want.erases), 32'(m_tdata[35:11]));
                check_field("bad_block_total", 32'(want.bad_count), 32'(m_tdata[44:36]));
            end
        end
    end

    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int hot_base;
        int span;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ERASE_LIMIT;
        cfg_wdata <= '0;
        errors = 0;
        no_idle = 1'b0;
        foreach (flash_mem[i]) flash_mem[i] = ERASED_BYTE;
        foreach (wear_cnt[i]) wear_cnt[i] = '0;
        foreach (bad_flag[i]) bad_flag[i] = 1'b0;
        erase_total = '0;
        bad_total = '0;
        limit_reg = LIMIT_RESET;
        biu_reg = BLOCKS_RESET;

        add_chk(OP_READ, 0, 0, 0, ST_OK, 8'hFF, 1'b0);
        add_chk(OP_READ, 255, 511, 0, ST_OK, 8'hFF, 1'b0);
        add_chk(OP_TOTALS, 0, 0, 0, ST_OK, 8'h00, 1'b0);
        add_chk(OP_WRITE, 255, 511, 8'h00, ST_OK, 8'h00, 1'b0);
        add_op(OP_WRITE, 0, 0, 8'hA5);
        add_op(OP_READ, 255, 511, 0);
        add_chk(OP_QUERY, 3, 0, 0, ST_OK, 8'h00, 1'b0);
        add_op(OP_ERASE, 0, 0, 0);
        add_op(OP_READ, 0, 0, 0);
        add_chk(OP_MARK, 3, 0, 0, ST_OK, 8'h00, 1'b0);
        add_chk(OP_MARK, 3, 0, 0, ST_OK, 8'h00, 1'b0);
        add_chk(OP_READ, 3, 7, 0, ST_IO, 8'h00, 1'b0);
        add_chk(OP_WRITE, 3, 7, 8'hFF, ST_IO, 8'h00, 1'b0);
        add_chk(OP_ERASE, 3, 0, 0, ST_IO, 8'h00, 1'b0);
        add_chk(OP_QUERY, 3, 0, 0, ST_OK, 8'h00, 1'b1);
        add_op(OP_TOTALS, 0, 0, 0);
        add_chk(OPC_SPARE_6, 0, 0, 0, ST_INVAL, 8'h00, 1'b0);
        add_chk(OPC_SPARE_7, 255, 511, 8'hFF, ST_INVAL, 8'h00, 1'b0);
        add_cfg(CFG_BLOCKS_IN_USE, 16'd4);
        add_chk(OP_READ, 4, 0, 0, ST_INVAL, 8'h00, 1'b0);
        add_chk(OP_QUERY, 200, 0, 0, ST_OK, 8'h00, 1'b1);
        add_chk(OP_MARK, 4, 0, 0, ST_INVAL, 8'h00, 1'b0);
        add_cfg(CFG_ERASE_LIMIT, 16'd0);
        add_chk(OP_ERASE, 1, 0, 0, ST_IO, 8'h00, 1'b0);
        add_cfg(CFG_ERASE_LIMIT, 16'd1);
        add_cfg(CFG_BLOCKS_IN_USE, 16'd511);
        add_op(OP_ERASE, 255, 0, 0);
        add_chk(OP_ERASE, 255, 0, 0, ST_IO, 8'h00, 1'b0);
        add_op(OP_TOTALS, 0, 0, 0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            end else begin
                send_op(directed_rows[i].opc, directed_rows[i].blk, directed_rows[i].off,
                        directed_rows[i].wbyte, directed_rows[i].typed,
                        directed_rows[i].typed_result);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_reg(CFG_ERASE_LIMIT, 16'(phase_limit[p]));
            write_reg(CFG_BLOCKS_IN_USE, 16'(phase_biu[p]));
            no_idle = (p % 3 == 1);
            span = usable_blocks();
            hot_base = (span > 8) ? $urandom_range(0, span - 8) : 0;
            repeat (phase_items[p]) send_random(hot_base);
        end

        wait_idle();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fsbw_pkg.sv
rtl/fsbw_ram.sv
rtl/flash_block_store_with_wear_top.sv
dv/tb_flash_block_store_with_wear_top.sv
